// ----- src/wss_pkg.sv -----
// Shared types, register codes and twiddle generation for the windowed STFT block.
// No dependencies; imported by every module of the block.
`default_nettype none
package wss_pkg;

  localparam logic [7:0] CFG_HOP_LENGTH = 8'd0;
  localparam logic [7:0] CFG_POWER_MODE = 8'd1;
  localparam logic [7:0] CFG_ONESIDED   = 8'd2;
  localparam logic [7:0] CFG_NORM_GAIN  = 8'd3;

  localparam logic       OP_LOAD   = 1'b0;
  localparam logic       OP_SAMPLE = 1'b1;

  localparam logic [1:0] PM_CPLX = 2'd0;
  localparam logic [1:0] PM_MAG  = 2'd1;
  localparam logic [1:0] PM_POW  = 2'd2;
  localparam logic [1:0] PM_RSVD = 2'd3;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam longint      ONE_Q30     = 64'sd1073741824;

  typedef struct packed {
    logic [6:0]  hop_length;
    logic [1:0]  power_mode;
    logic        onesided;
    logic [15:0] norm_gain;
  } cfg_t;

  typedef struct packed {
    logic               op;
    logic [5:0]         widx;
    logic signed [15:0] wval;
    logic signed [15:0] smp;
    logic               emit;
  } q_entry_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MAC, ST_SCL_RE, ST_SCL_IM, ST_SCL_WR,
    ST_RD, ST_SQ_RE, ST_SQ_IM, ST_SQRT, ST_OUT
  } back_state_t;

  function automatic logic [15:0] to_q15(input longint v);
    longint c;
    longint q;
    c = v;
    if (c < 0) c = 0;
    if (c > ONE_Q30) c = ONE_Q30;
    q = (c + 64'sd16384) >>> 15;
    if (q > 64'sd32767) q = 64'sd32767;
    return q[15:0];
  endfunction

  // Twiddle for a Q32 fraction of a full turn: {sin, cos} in Q1.15.
  function automatic logic [31:0] twiddle(input logic [63:0] t);
    logic [63:0] f;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] ts;
    logic [63:0] tc;
    longint      ss;
    longint      cs;
    logic [15:0] c;
    logic [15:0] s;
    logic [15:0] co;
    logic [15:0] si;
    f  = t & 64'h3FFF_FFFF;
    x  = (f * PI_HALF_Q30) >> 30;
    x2 = (x * x) >> 30;
    ts = x;
    tc = 64'(ONE_Q30);
    ss = longint'(x);
    cs = ONE_Q30;
    for (int n = 1; n <= 8; n++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if (n % 2 == 1) begin
        ss = ss - longint'(ts);
        cs = cs - longint'(tc);
      end else begin
        ss = ss + longint'(ts);
        cs = cs + longint'(tc);
      end
    end
    c = to_q15(cs);
    s = to_q15(ss);
    case (t[31:30])
      2'd0: begin co = c;  si = s;  end
      2'd1: begin co = -s; si = c;  end
      2'd2: begin co = -c; si = -s; end
      default: begin co = s; si = -c; end
    endcase
    return {si, co};
  endfunction

  // Shift right by 30, rounding ties away from zero, then saturate to 32 bits.
  function automatic logic [31:0] scale_sat(input logic signed [56:0] v);
    logic [56:0] mag;
    logic [56:0] t;
    logic [31:0] neg;
    mag = v[56] ? 57'(-v) : 57'(v);
    t   = (mag + 57'h2000_0000) >> 30;
    neg = ~t[31:0] + 32'd1;
    if (!v[56]) begin
      return (t > 57'h7FFF_FFFF) ? 32'h7FFF_FFFF : t[31:0];
    end
    return (t > 57'h8000_0000) ? 32'h8000_0000 : neg;
  endfunction

endpackage
`default_nettype wire

// ----- src/wss_queue.sv -----
// Four-entry queue between the front and back of the STFT block.
// Depends on wss_pkg for the entry type.
`default_nettype none
module wss_queue
  import wss_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  q_entry_t      push_data,
  output logic          full,
  input  wire logic     pop,
  output q_entry_t      head,
  output logic          empty
);

  q_entry_t   slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) slots[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 2'd1;
      if (pop && !empty) rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push && !full) - 3'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

// ----- src/wss_front.sv -----
// Input side: accepts beats, counts fill and hop, marks samples that close a frame.
// Depends on wss_pkg; feeds wss_queue.
`default_nettype none
module wss_front
  import wss_pkg::*;
#(
  parameter int N_FFT = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  cfg_t             cfg,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // window_index, window_value, sample, zero fill
  input  wire logic        s_tuser,   // operation
  output logic             push,
  output q_entry_t         push_data,
  input  wire logic        q_full
);

  localparam int FW = $clog2(N_FFT + 1);

  logic [FW-1:0] fill_count;
  logic [5:0]    hop_count;
  logic [6:0]    hop_eff;
  logic          filling;
  logic          emit;

  assign s_tready = !q_full;
  assign push     = s_tvalid && s_tready;

  always_comb begin
    if (cfg.hop_length == 7'd0) hop_eff = 7'd1;
    else if (cfg.hop_length > 7'd64) hop_eff = 7'd64;
    else hop_eff = cfg.hop_length;
  end

  assign filling = (fill_count != FW'(N_FFT));

  always_comb begin
    if (s_tuser != OP_SAMPLE) emit = 1'b0;
    else if (filling) emit = (fill_count + FW'(1) == FW'(N_FFT));
    else emit = ({1'b0, hop_count} + 7'd1 >= hop_eff);
  end

  always_comb begin
    push_data.op   = s_tuser;
    push_data.widx = s_tdata[5:0];
    push_data.wval = s_tdata[21:6];
    push_data.smp  = s_tdata[37:22];
    push_data.emit = emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      hop_count  <= '0;
    end else if (push && s_tuser == OP_SAMPLE) begin
      if (filling) begin
        fill_count <= fill_count + FW'(1);
        if (emit) hop_count <= '0;
      end else if (emit) begin
        hop_count <= '0;
      end else begin
        hop_count <= hop_count + 6'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- src/wss_back.sv -----
// Execution side: window table, sample ring, DFT accumulation, scaling, level and output.
// Depends on wss_pkg; drains wss_queue and drives the result stream.
`default_nettype none
module wss_back
  import wss_pkg::*;
#(
  parameter int N_FFT = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  cfg_t              cfg,
  input  q_entry_t          q_head,
  input  wire logic         q_empty,
  output logic              q_pop,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,
  output logic              m_tlast
);

  localparam int LW   = $clog2(N_FFT);
  localparam int CW   = LW + 1;
  localparam int HALF = N_FFT / 2 + 1;
  localparam int HW   = $clog2(HALF);

  back_state_t state, state_next;

  logic [31:0] tw [N_FFT];
  for (genvar g = 0; g < N_FFT; g++) begin : g_tw
    localparam logic [63:0] T = (64'(g) << 32) / N_FFT;
    assign tw[g] = twiddle(T);
  end

  logic signed [15:0] win_mem [64];
  logic [63:0]        win_vld;
  logic signed [15:0] ring_mem [N_FFT];
  logic [LW-1:0]      wp;

  logic [CW-1:0] kk;
  logic [CW-1:0] r;
  logic [CW-1:0] bin_i;
  logic [CW-1:0] bin_j;
  logic [CW-1:0] ring_sum;
  logic [CW-1:0] ring_addr;
  logic [CW-1:0] r_sum;
  logic [CW-1:0] r_next;
  logic          issue;
  logic          start;

  logic               s1_v, s1_first, s1_last;
  logic signed [15:0] ring_q;
  logic signed [15:0] win_q;
  logic               win_ok;
  logic signed [15:0] cos1, sin1;
  logic               s2_v, s2_first, s2_last;
  logic signed [31:0] prod;
  logic signed [15:0] cos2, sin2;
  logic               s3_v, s3_first, s3_last;
  logic signed [33:0] pre, pim;
  logic signed [39:0] acc_re, acc_im;
  logic signed [17:0] wx;
  logic [31:0]        wmag;
  logic [17:0]        wrnd;

  logic signed [39:0] mul_a;
  logic signed [56:0] mres;
  logic [31:0]        re_s;

  logic [31:0]  re_mem [HALF];
  logic [31:0]  im_mem [HALF];
  logic [31:0]  rd_re, rd_im;
  logic [CW-1:0] rd_addr;
  logic          mirror;
  logic [31:0]  cur_re, cur_im, im_fix;
  logic signed [31:0] sq_a;
  logic signed [63:0] sq;
  logic [63:0]  p;
  logic [63:0]  psum;
  logic [63:0]  sv, sres, sbit, trial;
  logic [CW-1:0] total;
  logic          out_free;
  logic [62:0]   level;

  logic [5:0]  out_bin;
  logic [31:0] out_re, out_im;
  logic [62:0] out_lvl;

  assign start    = (state == ST_IDLE) && !q_empty && q_head.op == OP_SAMPLE && q_head.emit;
  assign issue    = (state == ST_MAC) && (kk != CW'(N_FFT));
  assign total    = cfg.onesided ? CW'(HALF) : CW'(N_FFT);
  assign out_free = !m_tvalid || m_tready;

  assign ring_sum  = CW'(wp) + kk;
  assign ring_addr = (ring_sum >= CW'(N_FFT)) ? ring_sum - CW'(N_FFT) : ring_sum;
  assign r_sum     = r + bin_i;
  assign r_next    = (r_sum >= CW'(N_FFT)) ? r_sum - CW'(N_FFT) : r_sum;

  // round x*w to Q0, ties away from zero
  assign wmag = prod[31] ? 32'(-prod) : 32'(prod);
  assign wrnd = 18'((wmag + 32'h4000) >> 15);
  assign wx   = prod[31] ? -$signed(wrnd) : $signed(wrnd);

  assign mul_a = (state == ST_SCL_RE) ? acc_re : acc_im;

  assign rd_addr = (bin_j < CW'(HALF)) ? bin_j : CW'(N_FFT) - bin_j;
  assign mirror  = (bin_j >= CW'(HALF));
  assign im_fix  = mirror ? ((rd_im == 32'h8000_0000) ? 32'h7FFF_FFFF : 32'(-rd_im)) : rd_im;
  assign sq_a    = (state == ST_SQ_RE) ? $signed(rd_re) : $signed(cur_im);
  assign sq      = sq_a * sq_a;
  assign psum    = p + 64'(sq);
  assign trial   = sres + sbit;

  always_comb begin
    case (cfg.power_mode)
      PM_MAG:  level = sres[62:0];
      PM_POW:  level = p[63] ? {63{1'b1}} : p[62:0];
      default: level = '0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (start) state_next = ST_MAC;
      ST_MAC:    if (s3_v && s3_last) state_next = ST_SCL_RE;
      ST_SCL_RE: state_next = ST_SCL_IM;
      ST_SCL_IM: state_next = ST_SCL_WR;
      ST_SCL_WR: state_next = (bin_i == CW'(HALF - 1)) ? ST_RD : ST_MAC;
      ST_RD:     state_next = ST_SQ_RE;
      ST_SQ_RE:  state_next = ST_SQ_IM;
      ST_SQ_IM:  state_next = (cfg.power_mode == PM_MAG) ? ST_SQRT : ST_OUT;
      ST_SQRT:   if (sbit == 64'd1) state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) state_next = (bin_j == total - CW'(1)) ? ST_IDLE : ST_RD;
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state == ST_IDLE) && !q_empty;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // memories
  always_ff @(posedge clk) begin
    if (q_pop && q_head.op == OP_LOAD) win_mem[q_head.widx] <= q_head.wval;
    if (q_pop && q_head.op == OP_SAMPLE) ring_mem[wp] <= q_head.smp;
    ring_q <= ring_mem[ring_addr[LW-1:0]];
    win_q  <= win_mem[6'(kk[LW-1:0])];
    if (state == ST_SCL_WR) begin
      re_mem[bin_i[HW-1:0]] <= re_s;
      im_mem[bin_i[HW-1:0]] <= scale_sat(mres);
    end
    rd_re <= re_mem[rd_addr[HW-1:0]];
    rd_im <= im_mem[rd_addr[HW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      win_vld  <= '0;
      wp       <= '0;
      s1_v     <= 1'b0;
      s2_v     <= 1'b0;
      s3_v     <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (q_pop && q_head.op == OP_LOAD) win_vld[q_head.widx] <= 1'b1;
      if (q_pop && q_head.op == OP_SAMPLE) begin
        wp <= (wp == LW'(N_FFT - 1)) ? '0 : wp + LW'(1);
      end
      s1_v <= issue;
      s2_v <= s1_v;
      s3_v <= s2_v;
      if (state == ST_OUT && out_free) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    // MAC pipeline: read, x*w, products, accumulate
    win_ok   <= win_vld[6'(kk[LW-1:0])];
    s1_first <= (kk == '0);
    s1_last  <= (kk == CW'(N_FFT - 1));
    cos1     <= tw[r[LW-1:0]][15:0];
    sin1     <= tw[r[LW-1:0]][31:16];
    prod     <= ring_q * (win_ok ? win_q : 16'sd0);
    cos2     <= cos1;
    sin2     <= sin1;
    s2_first <= s1_first;
    s2_last  <= s1_last;
    pre      <= wx * cos2;
    pim      <= wx * sin2;
    s3_first <= s2_first;
    s3_last  <= s2_last;
    if (s3_v) begin
      acc_re <= s3_first ? 40'(pre) : acc_re + 40'(pre);
      acc_im <= s3_first ? -40'(pim) : acc_im - 40'(pim);
    end

    if (start) begin
      kk    <= '0;
      r     <= '0;
      bin_i <= '0;
    end else if (issue) begin
      kk <= kk + CW'(1);
      r  <= r_next;
    end

    unique case (state)
      ST_SCL_RE: mres <= mul_a * $signed({1'b0, cfg.norm_gain});
      ST_SCL_IM: begin
        re_s <= scale_sat(mres);
        mres <= mul_a * $signed({1'b0, cfg.norm_gain});
      end
      ST_SCL_WR: begin
        bin_i <= bin_i + CW'(1);
        kk    <= '0;
        r     <= '0;
        bin_j <= '0;
      end
      ST_SQ_RE: begin
        cur_re <= rd_re;
        cur_im <= im_fix;
        p      <= 64'(sq);
      end
      ST_SQ_IM: begin
        p    <= psum;
        sv   <= psum;
        sres <= '0;
        sbit <= 64'h4000_0000_0000_0000;
      end
      ST_SQRT: begin
        if (sv >= trial) begin
          sv   <= sv - trial;
          sres <= (sres >> 1) + sbit;
        end else begin
          sres <= sres >> 1;
        end
        sbit <= sbit >> 2;
      end
      ST_OUT: begin
        if (out_free) begin
          out_bin <= 6'(bin_j);
          out_re  <= cur_re;
          out_im  <= cur_im;
          out_lvl <= level;
          m_tlast <= (bin_j == total - CW'(1));
          bin_j   <= bin_j + CW'(1);
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {3'b000, out_lvl, out_im, out_re, out_bin};

endmodule
`default_nettype wire

// ----- src/windowed_stft_spectrogram.sv -----
// Top level of the windowed STFT spectrogram block: configuration registers and wiring.
// Depends on wss_pkg, wss_front, wss_queue and wss_back.
// Window loads and audio samples arrive as input beats; a four-entry queue lets the
// input keep accepting, until the queue is full, while a frame is computed. Loads and
// samples that close no frame are taken from the queue while the back end is idle.
// A frame runs one multiply-accumulate per cycle over the sample ring, bin by bin for
// N_FFT/2+1 bins, with pipeline drain and gain scaling after each bin. Each emitted
// bin then uses the bit-pair square root in magnitude mode and waits for a free output.
// Window coefficients not yet loaded read as zero; configuration is taken at any time.
`default_nettype none
module windowed_stft_spectrogram
  import wss_pkg::*;
#(
  parameter int N_FFT = 64
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [7:0]   cfg_index,
  input  wire logic [15:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [39:0]  s_tdata,   // window_index, window_value, sample, zero fill
  input  wire logic         s_tuser,   // operation
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [135:0]      m_tdata,   // bin_index, real_part, imag_part, level, zero fill
  output logic              m_tlast    // last_bin
);

  cfg_t     cfg;
  q_entry_t push_data;
  q_entry_t q_head;
  logic     push, q_full, q_pop, q_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hop_length <= 7'd16;
      cfg.power_mode <= PM_POW;
      cfg.onesided   <= 1'b1;
      cfg.norm_gain  <= 16'h8000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_HOP_LENGTH: cfg.hop_length <= cfg_data[6:0];
        CFG_POWER_MODE: cfg.power_mode <= cfg_data[1:0];
        CFG_ONESIDED:   cfg.onesided   <= cfg_data[0];
        CFG_NORM_GAIN:  cfg.norm_gain  <= cfg_data;
        default: ;
      endcase
    end
  end

  wss_front #(.N_FFT(N_FFT)) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .push      (push),
    .push_data (push_data),
    .q_full    (q_full)
  );

  wss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty)
  );

  wss_back #(.N_FFT(N_FFT)) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_head   (q_head),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule
`default_nettype wire
